FILE: hw/rtl/shortest_queue_dispatch_fifos_defines.svh
// assertion macros for the shortest-queue dispatcher
// used by shortest_queue_dispatch_fifos.sv, expects clk and rst_n in scope
`ifndef SHORTEST_QUEUE_DISPATCH_FIFOS_DEFINES_SVH
`define SHORTEST_QUEUE_DISPATCH_FIFOS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SQD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SQD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sqd_pkg.sv
// shared codes and default sizes for the shortest-queue dispatcher
// no dependencies
`default_nettype none

package sqd_pkg;

    localparam int NUM_QUEUES_DEF  = 4;
    localparam int DEPTH_DEF       = 256;
    localparam int HANDLE_BITS_DEF = 32;

    // request modes
    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_GET  = 2'd1;
    localparam logic [1:0] MODE_POP  = 2'd2;

    // response status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_INACTIVE = 2'd3;

    // register map
    localparam logic REG_ACTIVE_QUEUES = 1'b0;
    localparam logic [2:0] ACTIVE_QUEUES_RESET = 3'd4;

endpackage

`default_nettype wire

FILE: hw/rtl/sqd_ram.sv
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module sqd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sqd_pick.sv
// picks the active queue with the fewest entries, lowest index on a tie
// no dependencies
`default_nettype none

module sqd_pick #(
    parameter int NUM_QUEUES = 4,
    parameter int CW         = 8,
    localparam int QW        = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
    localparam int AW        = $clog2(NUM_QUEUES + 1)
) (
    input  wire logic [NUM_QUEUES*CW-1:0] counts,
    input  wire logic [AW-1:0]            act,
    output logic      [QW-1:0]            best,
    output logic      [CW-1:0]            best_count
);

    always_comb
    begin
        logic [CW-1:0] c;
        best       = '0;
        best_count = counts[CW-1:0];
        for (int i = 1; i < NUM_QUEUES; i++)
        begin
            c = counts[i*CW +: CW];
            // strict compare keeps the lowest index on equal counts
            if ((i < int'(act)) && (c < best_count))
            begin
                best       = QW'(i);
                best_count = c;
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/shortest_queue_dispatch_fifos.sv
// top level of the shortest-queue dispatcher: apb register, control, pointers
// depends on sqd_pkg, sqd_pick, sqd_ram and shortest_queue_dispatch_fifos_defines.svh
`default_nettype none

`include "shortest_queue_dispatch_fifos_defines.svh"

// One ring FIFO of task handles per worker queue, all held in a single
// synchronous slot memory of NUM_QUEUES*DEPTH words; a queue holds at most
// DEPTH-1 handles. A push goes to the active queue with the fewest entries
// (lowest index on a tie); get and pop dequeue from worker_index. Full, empty
// and inactive requests are answered with a status word and change nothing.
// Push, rejected requests and unknown modes give their response word in the
// cycle after acceptance; a successful get or pop first passes through
// S_READ for the registered read of the slot memory. A new word is accepted
// once the control is idle and the response register is free or being
// taken, so pushes run at one word per cycle while responses are taken;
// no word is accepted during S_READ. Occupancies and pointers live in
// flip-flops cleared by reset; the slot memory needs no clearing pass.
module shortest_queue_dispatch_fifos #(
    parameter int NUM_QUEUES  = sqd_pkg::NUM_QUEUES_DEF,
    parameter int DEPTH       = sqd_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = sqd_pkg::HANDLE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [1:0]  mode,
    input  wire logic [31:0] task_handle,
    input  wire logic [1:0]  worker_index,

    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic      [1:0]  status,
    output logic      [1:0]  chosen_queue,
    output logic      [31:0] handle_out,
    output logic      [7:0]  fill_level
);

    localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int AW  = $clog2(NUM_QUEUES + 1);
    localparam int CW  = $clog2(DEPTH);
    localparam int MAW = $clog2(NUM_QUEUES * DEPTH);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t          state_reg, state_next;
    logic [2:0]      active_reg, active_next;
    logic [CW-1:0]   cnt_reg [NUM_QUEUES];
    logic [CW-1:0]   cnt_next [NUM_QUEUES];
    logic [CW-1:0]   wp_reg [NUM_QUEUES];
    logic [CW-1:0]   wp_next [NUM_QUEUES];
    logic [CW-1:0]   rp_reg [NUM_QUEUES];
    logic [CW-1:0]   rp_next [NUM_QUEUES];
    logic            rsp_valid_reg, rsp_valid_next;
    logic [1:0]      status_reg, status_next;
    logic [1:0]      chosen_reg, chosen_next;
    logic [31:0]     handle_reg, handle_next;
    logic [7:0]      fill_reg, fill_next;
    logic            get_reg, get_next;

    logic [AW-1:0]            act;
    logic [NUM_QUEUES*CW-1:0] counts_flat;
    logic [QW-1:0]            best;
    logic [CW-1:0]            best_count;
    logic [QW-1:0]            idx_q;
    logic                     req_fire;
    logic                     cfg_write;

    logic                   ram_en;
    logic                   ram_we;
    logic [MAW-1:0]         ram_addr;
    logic [HANDLE_BITS-1:0] ram_wdata;
    logic [HANDLE_BITS-1:0] ram_rdata;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == sqd_pkg::REG_ACTIVE_QUEUES) ? {29'd0, active_reg} : 32'd0;

    // active count clamped to 1..NUM_QUEUES
    always_comb
    begin
        if (active_reg == 3'd0)
        begin
            act = AW'(1);
        end
        else if (int'(active_reg) > NUM_QUEUES)
        begin
            act = AW'(NUM_QUEUES);
        end
        else
        begin
            act = AW'(active_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            counts_flat[i*CW +: CW] = cnt_reg[i];
        end
    end

    sqd_pick #(
        .NUM_QUEUES (NUM_QUEUES),
        .CW         (CW)
    ) u_pick (
        .counts     (counts_flat),
        .act        (act),
        .best       (best),
        .best_count (best_count)
    );

    sqd_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (NUM_QUEUES * DEPTH)
    ) u_slots (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign idx_q     = QW'(worker_index);
    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign req_fire  = req_valid && req_ready;
    assign ram_wdata = HANDLE_BITS'(task_handle);

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign chosen_queue = chosen_reg;
    assign handle_out   = handle_reg;
    assign fill_level   = fill_reg;

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        cnt_next       = cnt_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        chosen_next    = chosen_reg;
        handle_next    = handle_reg;
        fill_next      = fill_reg;
        get_next       = get_reg;
        ram_en         = 1'b0;
        ram_we         = 1'b0;
        ram_addr       = '0;

        if (cfg_write && (paddr[2] == sqd_pkg::REG_ACTIVE_QUEUES))
        begin
            active_next = pwdata[2:0];
        end

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    handle_next = 32'd0;
                    case (mode)
                        sqd_pkg::MODE_PUSH:
                        begin
                            rsp_valid_next = 1'b1;
                            chosen_next    = 2'(best);
                            if (best_count == CW'(DEPTH - 1))
                            begin
                                status_next = sqd_pkg::ST_FULL;
                                fill_next   = 8'(best_count);
                            end
                            else
                            begin
                                status_next    = sqd_pkg::ST_OK;
                                fill_next      = 8'(best_count + CW'(1));
                                cnt_next[best] = best_count + CW'(1);
                                wp_next[best]  = (wp_reg[best] == CW'(DEPTH - 1)) ?
                                                 '0 : wp_reg[best] + CW'(1);
                                ram_en         = 1'b1;
                                ram_we         = 1'b1;
                                ram_addr       = MAW'(best * DEPTH) + MAW'(wp_reg[best]);
                            end
                        end
                        sqd_pkg::MODE_GET, sqd_pkg::MODE_POP:
                        begin
                            chosen_next = worker_index;
                            if (int'(worker_index) >= int'(act))
                            begin
                                rsp_valid_next = 1'b1;
                                status_next    = sqd_pkg::ST_INACTIVE;
                                fill_next      = 8'd0;
                            end
                            else if (cnt_reg[idx_q] == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                status_next    = sqd_pkg::ST_EMPTY;
                                fill_next      = 8'd0;
                            end
                            else
                            begin
                                // response waits in S_READ for the slot read
                                state_next      = S_READ;
                                get_next        = (mode == sqd_pkg::MODE_GET);
                                fill_next       = 8'(cnt_reg[idx_q] - CW'(1));
                                cnt_next[idx_q] = cnt_reg[idx_q] - CW'(1);
                                rp_next[idx_q]  = (rp_reg[idx_q] == CW'(DEPTH - 1)) ?
                                                  '0 : rp_reg[idx_q] + CW'(1);
                                ram_en          = 1'b1;
                                ram_addr        = MAW'(idx_q * DEPTH) + MAW'(rp_reg[idx_q]);
                            end
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                            status_next    = sqd_pkg::ST_INACTIVE;
                            chosen_next    = 2'd0;
                            fill_next      = 8'd0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                state_next     = S_IDLE;
                rsp_valid_next = 1'b1;
                status_next    = sqd_pkg::ST_OK;
                handle_next    = get_reg ? 32'(ram_rdata) : 32'd0;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= sqd_pkg::ACTIVE_QUEUES_RESET;
            rsp_valid_reg <= 1'b0;
            get_reg       <= 1'b0;
            status_reg    <= sqd_pkg::ST_OK;
            chosen_reg    <= 2'd0;
            handle_reg    <= 32'd0;
            fill_reg      <= 8'd0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                cnt_reg[i] <= '0;
                wp_reg[i]  <= '0;
                rp_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            rsp_valid_reg <= rsp_valid_next;
            get_reg       <= get_next;
            status_reg    <= status_next;
            chosen_reg    <= chosen_next;
            handle_reg    <= handle_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
        end
    end

    // no new word while a slot read is in flight
    `SQD_ASSERT_NOW(a_no_accept_in_read, state_reg == S_READ, !req_ready && !rsp_valid_reg, "word accepted or response shown during slot read")
    // a dequeue that starts a read produces an ok response next cycle
    `SQD_ASSERT_NEXT(a_read_completes, state_reg == S_READ, rsp_valid_reg && status_reg == sqd_pkg::ST_OK && state_reg == S_IDLE, "slot read did not complete")
    // rejected requests never carry a handle
    `SQD_ASSERT_NOW(a_reject_zero_handle, rsp_valid_reg && status_reg != sqd_pkg::ST_OK, handle_reg == 32'd0, "rejected response carries a handle")

endmodule

`default_nettype wire
